// ----- hdl/tmw_pkg.sv -----
// ----------------------------------------------------------------------------
// tmw_pkg
// Shared constants and types for the time-window moving average.
// ----------------------------------------------------------------------------
package tmw_pkg;

  localparam int QADDR_W        = 10;
  localparam int QUEUE_DEPTH    = 1 << QADDR_W;
  localparam int QCNT_W         = QADDR_W + 1;
  localparam int TIME_FRAC_BITS = 10;

  localparam int TIME_W  = 27;
  localparam int SEC_W   = 17;
  localparam int WIN_W   = 12;
  localparam int PWR_W   = 13;
  localparam int HR_W    = 9;
  localparam int KPH_W   = 16;
  localparam int CAD_W   = 9;
  localparam int IV_W    = 8;
  localparam int PEND_W  = 4;

  localparam int WATT_W  = 12;
  localparam int HRV_W   = 8;
  localparam int MPH_W   = 15;
  localparam int CADV_W  = 8;

  localparam int AVG_W_W  = 16;
  localparam int AVG_HR_W = 12;
  localparam int AVG_SP_W = 19;
  localparam int AVG_CD_W = 12;

  localparam int FRAC_OUT  = 4;
  localparam int SUM_W_W   = WATT_W + QADDR_W;
  localparam int SUM_HR_W  = HRV_W + QADDR_W;
  localparam int SUM_SP_W  = MPH_W + QADDR_W;
  localparam int SUM_CD_W  = CADV_W + QADDR_W;
  localparam int DIVD_W    = SUM_SP_W + FRAC_OUT;
  localparam int QUO_W     = MPH_W + FRAC_OUT;
  localparam int REM_W     = QCNT_W + 1;
  localparam int DCNT_W    = $clog2(QUO_W + 1);

  localparam int LIMIT_W   = SEC_W + TIME_FRAC_BITS;
  localparam int CMP_W     = (LIMIT_W > TIME_W) ? LIMIT_W : TIME_W;

  localparam int          MPH_MUL_W = 16;
  localparam logic [15:0] MPH_Q16   = 16'd40722;

  localparam int          CFG_DATA_W     = 32;
  localparam int          CFG_ADDR_W     = 3;
  localparam logic [15:0] WINDOW_RESET   = 16'd30;
  localparam logic        REG_WINDOW_SEL = 1'b0;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [CADV_W-1:0] cad;
    logic [MPH_W-1:0]  mph;
    logic [HRV_W-1:0]  hr;
    logic [WATT_W-1:0] watts;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [QADDR_W-1:0] addr;
    entry_t             data;
  } q_wr_t;

  typedef struct packed {
    logic               en;
    logic [QADDR_W-1:0] addr;
  } q_rd_t;

  typedef struct packed {
    logic              go;
    logic [DIVD_W-1:0] dividend;
    logic [QCNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/tmw_if.sv -----
// ----------------------------------------------------------------------------
// tmw_in_if / tmw_out_if
// Valid/ready channels for sample and tick items and for averaged results.
// ----------------------------------------------------------------------------
interface tmw_in_if
  import tmw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [TIME_W-1:0]        sample_time;
  logic signed [PWR_W-1:0]  power_watts;
  logic signed [HR_W-1:0]   heart_rate;
  logic signed [KPH_W-1:0]  speed_kph;
  logic signed [CAD_W-1:0]  cadence;
  logic [IV_W-1:0]          interval_id;
  logic [SEC_W-1:0]         tick_second;

  modport source (output valid, mode, sample_time, power_watts, heart_rate, speed_kph,
                  cadence, interval_id, tick_second, input ready);
  modport sink   (input valid, mode, sample_time, power_watts, heart_rate, speed_kph,
                  cadence, interval_id, tick_second, output ready);
endinterface

interface tmw_out_if
  import tmw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SEC_W-1:0]    out_second;
  logic [AVG_W_W-1:0]  avg_watts;
  logic [AVG_HR_W-1:0] avg_heart_rate;
  logic [AVG_SP_W-1:0] avg_speed_mph;
  logic [AVG_CD_W-1:0] avg_cadence;
  logic                window_empty;
  logic [PEND_W-1:0]   new_intervals;
  logic                overflow;

  modport source (output valid, out_second, avg_watts, avg_heart_rate, avg_speed_mph,
                  avg_cadence, window_empty, new_intervals, overflow, input ready);
  modport sink   (input valid, out_second, avg_watts, avg_heart_rate, avg_speed_mph,
                  avg_cadence, window_empty, new_intervals, overflow, output ready);
endinterface

// ----- hdl/time_window_moving_average.sv -----
// ----------------------------------------------------------------------------
// time_window_moving_average
// Time-window moving average of power, heart rate, speed and cadence.
//
// in_ch carries sample transactions (mode 0) and second ticks (mode 1);
// out_ch returns one averaged result per tick, none per sample. The
// window length is written over the APB port at byte address 0.
// A sample is clamped and checked for a new interval, then the speed
// is multiplied, the queue written and the sums updated. A tick is
// latched, then each evicted sample is read, compared and subtracted,
// and a final read stops the walk; the four channels then pass in turn
// through the shared serial divider, and the result is loaded into the
// output register. Early ticks and an empty window skip the divider.
// in_ch.ready is high only while the sequencer idles. A result waits in
// the output register while out_ch stalls; samples are still taken, a
// tick waits at its last step.
// Reset clears the queue pointers, sums, counters and flags and sets the
// window to 30 s; the sample store itself needs no clearing.
// ----------------------------------------------------------------------------
module time_window_moving_average
  import tmw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tmw_in_if.sink                in_ch,
  tmw_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SAMPLE   = 3'd1;
  localparam logic [2:0] ST_EV_RD    = 3'd2;
  localparam logic [2:0] ST_EV_CMP   = 3'd3;
  localparam logic [2:0] ST_DIV_GO   = 3'd4;
  localparam logic [2:0] ST_DIV_WAIT = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  localparam logic [1:0] CH_WATTS = 2'd0;
  localparam logic [1:0] CH_HR    = 2'd1;
  localparam logic [1:0] CH_SPEED = 2'd2;
  localparam logic [1:0] CH_CAD   = 2'd3;

  logic [2:0]          state_r, state_nxt;
  logic [WIN_W-1:0]    window_r, window_nxt;
  logic [QADDR_W-1:0]  pos_r, pos_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W_W-1:0]  sw_r, sw_nxt;
  logic [SUM_HR_W-1:0] sh_r, sh_nxt;
  logic [SUM_SP_W-1:0] ss_r, ss_nxt;
  logic [SUM_CD_W-1:0] sc_r, sc_nxt;
  logic [IV_W-1:0]     prev_iv_r, prev_iv_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic                ovf_r, ovf_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic                empty_r, empty_nxt;
  logic [SEC_W-1:0]    sec_r, sec_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic [WATT_W-1:0]   w_r, w_nxt;
  logic [HRV_W-1:0]    h_r, h_nxt;
  logic [KPH_W-1:0]    k_r, k_nxt;
  logic [CADV_W-1:0]   c_r, c_nxt;
  logic [QUO_W-1:0]    qw_r, qw_nxt;
  logic [QUO_W-1:0]    qh_r, qh_nxt;
  logic [QUO_W-1:0]    qs_r, qs_nxt;
  logic [QUO_W-1:0]    qc_r, qc_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SEC_W-1:0]    o_sec_r, o_sec_nxt;
  logic [AVG_W_W-1:0]  o_w_r, o_w_nxt;
  logic [AVG_HR_W-1:0] o_h_r, o_h_nxt;
  logic [AVG_SP_W-1:0] o_s_r, o_s_nxt;
  logic [AVG_CD_W-1:0] o_c_r, o_c_nxt;
  logic                o_empty_r, o_empty_nxt;
  logic [PEND_W-1:0]   o_pend_r, o_pend_nxt;
  logic                o_ovf_r, o_ovf_nxt;

  q_wr_t    q_wr;
  q_rd_t    q_rd;
  entry_t   q_data;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     in_acc;
  logic                     cfg_wr;
  logic [2*MPH_MUL_W-1:0]   mph_prod;
  logic [MPH_W-1:0]         mph;
  logic [SEC_W-1:0]         sec_diff;

  tmw_queue u_queue (
    .clk     (clk),
    .wr      (q_wr),
    .rd      (q_rd),
    .rd_data (q_data)
  );

  tmw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_WINDOW_SEL);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_SEL) ?
                      CFG_DATA_W'(window_r) : '0;

  assign mph_prod = MPH_MUL_W'(k_r) * MPH_Q16;
  assign mph      = mph_prod[MPH_MUL_W +: MPH_W];
  assign sec_diff = in_ch.tick_second - SEC_W'(window_r);

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = cfg_wr ? cfg_pwdata[WIN_W-1:0] : window_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    sw_nxt        = sw_r;
    sh_nxt        = sh_r;
    ss_nxt        = ss_r;
    sc_nxt        = sc_r;
    prev_iv_nxt   = prev_iv_r;
    pend_nxt      = pend_r;
    ovf_nxt       = ovf_r;
    ch_nxt        = ch_r;
    empty_nxt     = empty_r;
    sec_nxt       = sec_r;
    limit_nxt     = limit_r;
    t_nxt         = t_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    c_nxt         = c_r;
    qw_nxt        = qw_r;
    qh_nxt        = qh_r;
    qs_nxt        = qs_r;
    qc_nxt        = qc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_sec_nxt     = o_sec_r;
    o_w_nxt       = o_w_r;
    o_h_nxt       = o_h_r;
    o_s_nxt       = o_s_r;
    o_c_nxt       = o_c_r;
    o_empty_nxt   = o_empty_r;
    o_pend_nxt    = o_pend_r;
    o_ovf_nxt     = o_ovf_r;

    q_wr.en        = 1'b0;
    q_wr.addr      = pos_r + count_r[QADDR_W-1:0];
    q_wr.data      = '{stamp: t_r, cad: c_r, mph: mph, hr: h_r, watts: w_r};
    q_rd.en        = 1'b0;
    q_rd.addr      = pos_r;
    div_req.go     = 1'b0;
    div_req.divisor = count_r;
    unique case (ch_r)
      CH_WATTS: div_req.dividend = DIVD_W'({sw_r, {FRAC_OUT{1'b0}}});
      CH_HR:    div_req.dividend = DIVD_W'({sh_r, {FRAC_OUT{1'b0}}});
      CH_SPEED: div_req.dividend = DIVD_W'({ss_r, {FRAC_OUT{1'b0}}});
      default:  div_req.dividend = DIVD_W'({sc_r, {FRAC_OUT{1'b0}}});
    endcase

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode == MODE_SAMPLE) begin
            t_nxt = in_ch.sample_time;
            w_nxt = in_ch.power_watts[PWR_W-1] ? '0 : in_ch.power_watts[WATT_W-1:0];
            h_nxt = in_ch.heart_rate[HR_W-1]   ? '0 : in_ch.heart_rate[HRV_W-1:0];
            k_nxt = in_ch.speed_kph[KPH_W-1]   ? '0 : in_ch.speed_kph;
            c_nxt = in_ch.cadence[CAD_W-1]     ? '0 : in_ch.cadence[CADV_W-1:0];
            if (in_ch.interval_id != prev_iv_r) begin
              prev_iv_nxt = in_ch.interval_id;
              if (pend_r != {PEND_W{1'b1}}) begin
                pend_nxt = pend_r + 1'b1;
              end
            end
            if (count_r == QCNT_W'(QUEUE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              state_nxt = ST_SAMPLE;
            end
          end else begin
            sec_nxt   = in_ch.tick_second;
            empty_nxt = 1'b1;
            qw_nxt    = '0;
            qh_nxt    = '0;
            qs_nxt    = '0;
            qc_nxt    = '0;
            ch_nxt    = CH_WATTS;
            limit_nxt = LIMIT_W'(sec_diff) << TIME_FRAC_BITS;
            if (in_ch.tick_second < SEC_W'(window_r)) begin
              state_nxt = ST_FINISH;
            end else begin
              state_nxt = ST_EV_RD;
            end
          end
        end
      end
      ST_SAMPLE: begin
        q_wr.en   = 1'b1;
        count_nxt = count_r + 1'b1;
        sw_nxt    = sw_r + SUM_W_W'(w_r);
        sh_nxt    = sh_r + SUM_HR_W'(h_r);
        ss_nxt    = ss_r + SUM_SP_W'(mph);
        sc_nxt    = sc_r + SUM_CD_W'(c_r);
        state_nxt = ST_IDLE;
      end
      ST_EV_RD: begin
        if (count_r == '0) begin
          state_nxt = ST_DIV_GO;
        end else begin
          q_rd.en   = 1'b1;
          state_nxt = ST_EV_CMP;
        end
      end
      ST_EV_CMP: begin
        if (CMP_W'(q_data.stamp) < CMP_W'(limit_r)) begin
          sw_nxt    = sw_r - SUM_W_W'(q_data.watts);
          sh_nxt    = sh_r - SUM_HR_W'(q_data.hr);
          ss_nxt    = ss_r - SUM_SP_W'(q_data.mph);
          sc_nxt    = sc_r - SUM_CD_W'(q_data.cad);
          pos_nxt   = pos_r + 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = ST_EV_RD;
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        if (count_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          div_req.go = 1'b1;
          state_nxt  = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          empty_nxt = 1'b0;
          unique case (ch_r)
            CH_WATTS: qw_nxt = div_rsp.quotient;
            CH_HR:    qh_nxt = div_rsp.quotient;
            CH_SPEED: qs_nxt = div_rsp.quotient;
            default:  qc_nxt = div_rsp.quotient;
          endcase
          if (ch_r == CH_CAD) begin
            state_nxt = ST_FINISH;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_sec_nxt     = sec_r;
          o_w_nxt       = qw_r[AVG_W_W-1:0];
          o_h_nxt       = qh_r[AVG_HR_W-1:0];
          o_s_nxt       = qs_r[AVG_SP_W-1:0];
          o_c_nxt       = qc_r[AVG_CD_W-1:0];
          o_empty_nxt   = empty_r;
          o_pend_nxt    = pend_r;
          o_ovf_nxt     = ovf_r;
          pend_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET[WIN_W-1:0];
      pos_r       <= '0;
      count_r     <= '0;
      sw_r        <= '0;
      sh_r        <= '0;
      ss_r        <= '0;
      sc_r        <= '0;
      prev_iv_r   <= '0;
      pend_r      <= '0;
      ovf_r       <= 1'b0;
      ch_r        <= CH_WATTS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      sw_r        <= sw_nxt;
      sh_r        <= sh_nxt;
      ss_r        <= ss_nxt;
      sc_r        <= sc_nxt;
      prev_iv_r   <= prev_iv_nxt;
      pend_r      <= pend_nxt;
      ovf_r       <= ovf_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    empty_r   <= empty_nxt;
    sec_r     <= sec_nxt;
    limit_r   <= limit_nxt;
    t_r       <= t_nxt;
    w_r       <= w_nxt;
    h_r       <= h_nxt;
    k_r       <= k_nxt;
    c_r       <= c_nxt;
    qw_r      <= qw_nxt;
    qh_r      <= qh_nxt;
    qs_r      <= qs_nxt;
    qc_r      <= qc_nxt;
    o_sec_r   <= o_sec_nxt;
    o_w_r     <= o_w_nxt;
    o_h_r     <= o_h_nxt;
    o_s_r     <= o_s_nxt;
    o_c_r     <= o_c_nxt;
    o_empty_r <= o_empty_nxt;
    o_pend_r  <= o_pend_nxt;
    o_ovf_r   <= o_ovf_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_second     = o_sec_r;
  assign out_ch.avg_watts      = o_w_r;
  assign out_ch.avg_heart_rate = o_h_r;
  assign out_ch.avg_speed_mph  = o_s_r;
  assign out_ch.avg_cadence    = o_c_r;
  assign out_ch.window_empty   = o_empty_r;
  assign out_ch.new_intervals  = o_pend_r;
  assign out_ch.overflow       = o_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.go |-> count_r != '0)
    else $error("divider started with zero count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_empty_r) |->
      (o_w_r == '0 && o_h_r == '0 && o_s_r == '0 && o_c_r == '0))
    else $error("empty window reported nonzero average");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && state_nxt == ST_IDLE) |=> (pend_r == '0 && out_valid_r))
    else $error("interval count not cleared after result load");

endmodule

// ----- hdl/tmw_div.sv -----
// ----------------------------------------------------------------------------
// tmw_div
// Restoring divider, one quotient bit per cycle, shared by all four channels.
// ----------------------------------------------------------------------------
module tmw_div
  import tmw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  dvd_r, dvd_nxt;
  logic [QCNT_W-1:0] dsr_r, dsr_nxt;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign trial = {rem_r[REM_W-2:0], dvd_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(QUO_W);
      rem_nxt  = REM_W'(req.dividend[DIVD_W-1:QUO_W]);
      dvd_nxt  = req.dividend[QUO_W-1:0];
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, dsr_r}) : trial;
      dvd_nxt = {dvd_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// ----- hdl/tmw_queue.sv -----
// ----------------------------------------------------------------------------
// tmw_queue
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tmw_queue
  import tmw_pkg::*;
(
  input  logic   clk,
  input  q_wr_t  wr,
  input  q_rd_t  rd,
  output entry_t rd_data
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
